@@ hdl/pic_pkg.sv @@
// shared types and constants for the point-in-cylinder test
// no dependencies; imported by every pic module
`timescale 1ns / 1ps

package pic_pkg;

    // field widths
    localparam int COORD_W  = 32;   // Q16.16 coordinate
    localparam int AXIS_W   = 18;   // Q1.16 axis component
    localparam int LEN_W    = 31;   // unsigned Q15.16 height / radius
    localparam int DIFF_W   = COORD_W + 1;          // offset from base
    localparam int PROD_W   = DIFF_W + AXIS_W;      // d * a, Q.32
    localparam int ACC_W    = PROD_W + 2;           // sum of three products
    localparam int FRAC_DROP = 16;                  // Q.32 -> Q.16
    localparam int PROJ_W   = ACC_W - FRAC_DROP;    // rounded projection
    localparam int PA_W     = PROJ_W + AXIS_W;      // proj * a, Q.32
    localparam int RND_W    = PA_W - FRAC_DROP;     // rounded proj * a
    localparam int PERP_W   = RND_W + 1;            // perpendicular component
    localparam int MAG_W    = 32;                   // |perp| when in range
    localparam int SQ_W     = 2 * MAG_W;            // square / sum of squares
    localparam int HCMP_W   = PROJ_W + 1;           // height compare width

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 4'd7;

    localparam int UNIT_AXIS = 65536;
    localparam int UNIT_LEN  = 65536;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [AXIS_W-1:0]  axis_t;
    typedef logic        [LEN_W-1:0]   len_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROJ_W-1:0]  proj_t;

    // control that travels alongside each beat
    typedef struct packed {
        logic valid;
        logic hok;   // height check passed
        logic far;   // some perpendicular component beyond 2^31
    } pic_tag_t;

endpackage

@@ hdl/point_in_cylinder_test.sv @@
// point-in-cylinder test: one point accepted on any cycle, busy is never raised
// done pulses from the last of the eight register stages (offset, products,
// projection, proj*axis, perpendicular, squares, sum, compare) that a point
// passes after its start cycle; throughput one point per cycle
// results cannot be held off; reset clears the pipeline valids and returns the
// cylinder registers to a unit cylinder on the z axis at the origin
`timescale 1ns / 1ps

module point_in_cylinder_test #(
    parameter int TOLERANCE_LSB = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [31:0]              point_x,
    input  logic signed [31:0]              point_y,
    input  logic signed [31:0]              point_z,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    output logic                            done,
    output logic                            inside_res,
    output logic                            within_height,
    output logic                            within_radius
);
    import pic_pkg::*;

    coord_t   base_x_reg, base_y_reg, base_z_reg;
    axis_t    axis_x_reg, axis_y_reg, axis_z_reg;
    len_t     height_reg, radius_reg;
    coord_t   point [3];
    coord_t   base  [3];
    axis_t    axis  [3];
    pic_tag_t tag_proj, tag_perp;
    diff_t    d_proj [3];
    proj_t    proj;
    logic [MAG_W-1:0] mag [3];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg <= '0;
            base_y_reg <= '0;
            base_z_reg <= '0;
            axis_x_reg <= '0;
            axis_y_reg <= '0;
            axis_z_reg <= AXIS_W'(UNIT_AXIS);
            height_reg <= LEN_W'(UNIT_LEN);
            radius_reg <= LEN_W'(UNIT_LEN);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_X: base_x_reg <= cfg_data;
                REG_BASE_Y: base_y_reg <= cfg_data;
                REG_BASE_Z: base_z_reg <= cfg_data;
                REG_AXIS_X: axis_x_reg <= cfg_data[AXIS_W-1:0];
                REG_AXIS_Y: axis_y_reg <= cfg_data[AXIS_W-1:0];
                REG_AXIS_Z: axis_z_reg <= cfg_data[AXIS_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[LEN_W-1:0];
                REG_RADIUS: radius_reg <= cfg_data[LEN_W-1:0];
                default:    ;  // unknown index, beat dropped
            endcase
        end
    end

    assign point[0] = point_x;
    assign point[1] = point_y;
    assign point[2] = point_z;
    assign base[0]  = base_x_reg;
    assign base[1]  = base_y_reg;
    assign base[2]  = base_z_reg;
    assign axis[0]  = axis_x_reg;
    assign axis[1]  = axis_y_reg;
    assign axis[2]  = axis_z_reg;

    pic_proj u_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .point    (point),
        .base     (base),
        .axis     (axis),
        .tag_out  (tag_proj),
        .d_out    (d_proj),
        .proj_out (proj)
    );

    pic_perp #(
        .TOLERANCE_LSB (TOLERANCE_LSB)
    ) u_perp (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_proj),
        .d_in    (d_proj),
        .proj_in (proj),
        .axis    (axis),
        .height  (height_reg),
        .tag_out (tag_perp),
        .mag_out (mag)
    );

    pic_dist #(
        .TOLERANCE_LSB (TOLERANCE_LSB)
    ) u_dist (
        .clk           (clk),
        .rst_n         (rst_n),
        .tag_in        (tag_perp),
        .mag_in        (mag),
        .radius        (radius_reg),
        .done          (done),
        .inside_res    (inside_res),
        .within_height (within_height),
        .within_radius (within_radius)
    );

endmodule

@@ hdl/pic_proj.sv @@
// offset from the base and axial projection, three register stages
// depends on pic_pkg
`timescale 1ns / 1ps

module pic_proj (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  pic_pkg::coord_t   point [3],
    input  pic_pkg::coord_t   base  [3],
    input  pic_pkg::axis_t    axis  [3],
    output pic_pkg::pic_tag_t tag_out,
    output pic_pkg::diff_t    d_out [3],
    output pic_pkg::proj_t    proj_out
);
    import pic_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg;
    diff_t                    d1_reg [3];
    diff_t                    d2_reg [3];
    diff_t                    d3_reg [3];
    logic signed [PROD_W-1:0] prod_reg  [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [ACC_W-1:0]  acc_next;
    proj_t                    proj_reg, proj_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = PROD_W'(d1_reg[i]) * PROD_W'(axis[i]);
        end
        // round half up on the way from Q.32 to Q.16
        acc_next = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2])
                 + ACC_W'(1 << (FRAC_DROP - 1));
        proj_next = acc_next[ACC_W-1:FRAC_DROP];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_reg[i]   <= DIFF_W'(point[i]) - DIFF_W'(base[i]);
            prod_reg[i] <= prod_next[i];
            d2_reg[i]   <= d1_reg[i];
            d3_reg[i]   <= d2_reg[i];
        end
        proj_reg <= proj_next;
    end

    assign tag_out = '{valid: v3_reg, hok: 1'b0, far: 1'b0};
    assign d_out    = d3_reg;
    assign proj_out = proj_reg;

endmodule

@@ hdl/pic_perp.sv @@
// height check and perpendicular components, two register stages
// depends on pic_pkg
`timescale 1ns / 1ps

module pic_perp #(
    parameter int TOLERANCE_LSB = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pic_pkg::pic_tag_t tag_in,
    input  pic_pkg::diff_t    d_in [3],
    input  pic_pkg::proj_t    proj_in,
    input  pic_pkg::axis_t    axis [3],
    input  pic_pkg::len_t     height,
    output pic_pkg::pic_tag_t tag_out,
    output logic [pic_pkg::MAG_W-1:0] mag_out [3]
);
    import pic_pkg::*;

    localparam logic signed [PERP_W-1:0] PERP_LIM = PERP_W'(64'sd1 <<< MAG_W-1);

    logic                     v4_reg, v5_reg;
    logic                     hok4_reg, hok5_reg, far5_reg;
    logic                     hok_next, far_next;
    diff_t                    d4_reg [3];
    logic signed [PA_W-1:0]   pa_reg [3];
    logic signed [PA_W-1:0]   pa_rnd [3];
    logic signed [PERP_W-1:0] perp [3];
    logic signed [PERP_W-1:0] perp_abs [3];
    logic signed [HCMP_W-1:0] pj, lo, hi;
    logic [MAG_W-1:0]         mag_reg  [3];
    logic [MAG_W-1:0]         mag_next [3];

    always_comb
    begin
        pj = HCMP_W'(proj_in);
        lo = -HCMP_W'(TOLERANCE_LSB);
        hi = $signed({{(HCMP_W-LEN_W){1'b0}}, height}) + HCMP_W'(TOLERANCE_LSB);
        hok_next = (pj >= lo) && (pj <= hi);

        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            pa_rnd[i]   = pa_reg[i] + PA_W'(1 << (FRAC_DROP - 1));
            perp[i]     = PERP_W'(d4_reg[i]) - PERP_W'($signed(pa_rnd[i][PA_W-1:FRAC_DROP]));
            perp_abs[i] = perp[i][PERP_W-1] ? -perp[i] : perp[i];
            if ((perp[i] > PERP_LIM) || (perp[i] < -PERP_LIM))
            begin
                far_next = 1'b1;
            end
            mag_next[i] = perp_abs[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= tag_in.valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hok4_reg <= hok_next;
        hok5_reg <= hok4_reg;
        far5_reg <= far_next;
        for (int i = 0; i < 3; i++)
        begin
            pa_reg[i]  <= PA_W'(proj_in) * PA_W'(axis[i]);
            d4_reg[i]  <= d_in[i];
            mag_reg[i] <= mag_next[i];
        end
    end

    assign tag_out = '{valid: v5_reg, hok: hok5_reg, far: far5_reg};
    assign mag_out = mag_reg;

endmodule

@@ hdl/pic_dist.sv @@
// squared perpendicular distance against the radius limit, three register stages
// depends on pic_pkg
`timescale 1ns / 1ps

module pic_dist #(
    parameter int TOLERANCE_LSB = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pic_pkg::pic_tag_t tag_in,
    input  logic [pic_pkg::MAG_W-1:0] mag_in [3],
    input  pic_pkg::len_t     radius,
    output logic              done,
    output logic              inside_res,
    output logic              within_height,
    output logic              within_radius
);
    import pic_pkg::*;

    localparam logic [SQ_W-1:0] TOL_SQ = SQ_W'(TOLERANCE_LSB) << 16;

    logic             v6_reg, v7_reg, done_reg;
    logic             hok6_reg, hok7_reg, far6_reg, far7_reg;
    logic [SQ_W-1:0]  sq_reg [3];
    logic [SQ_W-1:0]  psq_reg;
    logic [SQ_W-1:0]  rsq_reg;
    logic             rok_next;
    logic             inside_reg, hok_out_reg, rok_out_reg;

    // user must keep radius static while points flow (not enforced), so its square is simply kept registered
    always_comb
    begin
        rok_next = !far7_reg && (psq_reg <= rsq_reg + TOL_SQ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v6_reg   <= tag_in.valid;
            v7_reg   <= v6_reg;
            done_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rsq_reg  <= SQ_W'(radius) * SQ_W'(radius);
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= SQ_W'(mag_in[i]) * SQ_W'(mag_in[i]);
        end
        hok6_reg    <= tag_in.hok;
        far6_reg    <= tag_in.far;
        psq_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        hok7_reg    <= hok6_reg;
        far7_reg    <= far6_reg;
        hok_out_reg <= hok7_reg;
        rok_out_reg <= rok_next;
        inside_reg  <= hok7_reg && rok_next;
    end

    assign done          = done_reg;
    assign inside_res    = inside_reg;
    assign within_height = hok_out_reg;
    assign within_radius = rok_out_reg;

endmodule

@@ dv/tb_point_in_cylinder_test.sv @@
// self-checking testbench for point_in_cylinder_test: directed and random points
// under several cylinder settings, checked against an in-bench predictor
// depends on hdl/pic_pkg.sv and hdl/point_in_cylinder_test.sv
`timescale 1ns / 1ps

module tb_point_in_cylinder_test;

    import pic_pkg::*;

    localparam int TOL = 1;
    localparam longint FAR_LIMIT = 64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_RADIUS + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;
    localparam int IDLE_PCT = 7;

    typedef struct packed {
        logic in_cyl;
        logic height_ok;
        logic radius_ok;
    } verdict_t;

    class cyl_scoreboard;
        coord_t   base [3];
        axis_t    axis [3];
        len_t     height;
        len_t     radius;
        verdict_t verdict_q [$];
        int       errors;

        function new();
            base   = '{0, 0, 0};
            axis   = '{0, 0, axis_t'(UNIT_AXIS)};
            height = len_t'(UNIT_LEN);
            radius = len_t'(UNIT_LEN);
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_BASE_X: base[0] = data;
                REG_BASE_Y: base[1] = data;
                REG_BASE_Z: base[2] = data;
                REG_AXIS_X: axis[0] = data[AXIS_W-1:0];
                REG_AXIS_Y: axis[1] = data[AXIS_W-1:0];
                REG_AXIS_Z: axis[2] = data[AXIS_W-1:0];
                REG_HEIGHT: height  = data[LEN_W-1:0];
                REG_RADIUS: radius  = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function verdict_t predict_containment(coord_t px, coord_t py, coord_t pz);
            coord_t            pt [3];
            longint            d [3];
            longint            a [3];
            longint            perp;
            longint            acc;
            longint            proj;
            longint unsigned   mag;
            longint unsigned   psq;
            longint unsigned   limit;
            logic              hok;
            logic              rok;
            verdict_t          v;
            pt  = '{px, py, pz};
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = longint'(pt[i]) - longint'(base[i]);
                a[i] = longint'(axis[i]);
                acc += d[i] * a[i];
            end
            // round half up from Q.32 to Q.16
            proj = (acc + 32768) >>> 16;
            hok  = (proj >= -TOL) && (proj <= longint'(height) + TOL);
            rok  = 1'b1;
            psq  = 0;
            for (int i = 0; i < 3; i++)
            begin
                perp = d[i] - ((proj * a[i] + 32768) >>> 16);
                if (perp > FAR_LIMIT || perp < -FAR_LIMIT)
                    rok = 1'b0;
                mag = (perp < 0) ? -perp : perp;
                if (rok)
                    psq += mag * mag;
            end
            limit = longint'(radius);
            limit = limit * limit + (longint'(TOL) << 16);
            if (rok)
                rok = (psq <= limit);
            v.in_cyl    = hok && rok;
            v.height_ok = hok;
            v.radius_ok = rok;
            return v;
        endfunction

        function void note_point(coord_t px, coord_t py, coord_t pz);
            verdict_q = {verdict_q, predict_containment(px, py, pz)};
        endfunction

        function void check_result(logic got_in, logic got_h, logic got_r);
            verdict_t exp_v;
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: inside %0b height %0b radius %0b",
                         $time, got_in, got_h, got_r);
                errors++;
                return;
            end
            exp_v = verdict_q.pop_front();
            if (got_in !== exp_v.in_cyl)
            begin
                $display("%0t: inside_res expected %0b actual %0b", $time, exp_v.in_cyl, got_in);
                errors++;
            end
            if (got_h !== exp_v.height_ok)
            begin
                $display("%0t: within_height expected %0b actual %0b",
                         $time, exp_v.height_ok, got_h);
                errors++;
            end
            if (got_r !== exp_v.radius_ok)
            begin
                $display("%0t: within_radius expected %0b actual %0b",
                         $time, exp_v.radius_ok, got_r);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    coord_t               point_x;
    coord_t               point_y;
    coord_t               point_z;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 done;
    logic                 inside_res;
    logic                 within_height;
    logic                 within_radius;

    cyl_scoreboard sb;

    point_in_cylinder_test #(
        .TOLERANCE_LSB (TOL)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .inside_res    (inside_res),
        .within_height (within_height),
        .within_radius (within_radius)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(inside_res, within_height, within_radius);
    end

    function automatic longint pick_between(longint lo, longint hi);
        longint unsigned span;
        longint unsigned r;
        span = hi - lo + 1;
        r    = {$urandom, $urandom};
        return lo + longint'(r % span);
    endfunction

    // one beat on the point channel, optionally preceded by an idle cycle
    task automatic feed_point(coord_t px, coord_t py, coord_t pz, bit may_idle);
        if (may_idle && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            start   = 1'b0;
            point_x = $urandom;
            point_y = $urandom;
            point_z = $urandom;
        end
        @(negedge clk);
        start   = 1'b1;
        point_x = px;
        point_y = py;
        point_z = pz;
        do
            @(posedge clk);
        while (busy);
        sb.note_point(px, py, pz);
    endtask

    task automatic stop_feed();
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic wait_results_out();
        while (sb.verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        if ($urandom_range(99) < IDLE_PCT)
            @(negedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // all eight registers, junk in the unused upper bits of the narrow ones
    task automatic apply_config(coord_t bx, coord_t by, coord_t bz,
                                axis_t ax, axis_t ay, axis_t az, len_t h, len_t r);
        logic [31:0] junk;
        stop_feed();
        wait_results_out();
        junk = $urandom;
        cfg_write(REG_BASE_X, bx);
        cfg_write(REG_BASE_Y, by);
        cfg_write(REG_BASE_Z, bz);
        cfg_write(REG_AXIS_X, {junk[31:AXIS_W], ax});
        cfg_write(REG_AXIS_Y, {junk[AXIS_W-1:4], ay});
        cfg_write(REG_AXIS_Z, {junk[13:0], az});
        cfg_write(REG_HEIGHT, {junk[0], h});
        cfg_write(REG_RADIUS, {junk[1], r});
        if ($urandom_range(2) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
    endtask

    task automatic random_config();
        coord_t b [3];
        axis_t  a [3];
        len_t   h;
        len_t   r;
        int     kind;
        int     k;
        real    v [3];
        real    n;
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(3) == 0)
                b[i] = $urandom;
            else
                b[i] = coord_t'(pick_between(-(200 <<< 16), 200 <<< 16));
        end
        kind = $urandom_range(9);
        a    = '{0, 0, 0};
        if (kind == 0)
            a = '{0, 0, 0};
        else if (kind <= 2)
            for (int i = 0; i < 3; i++)
                a[i] = axis_t'($urandom);
        else if (kind <= 5)
        begin
            k    = $urandom_range(2);
            a[k] = $urandom_range(1) ? axis_t'(UNIT_AXIS) : axis_t'(-UNIT_AXIS);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                v[i] = real'($urandom_range(2000)) - 1000.0;
            n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
            if (n == 0.0)
            begin
                v[2] = 1.0;
                n    = 1.0;
            end
            for (int i = 0; i < 3; i++)
                a[i] = axis_t'($rtoi(v[i] / n * 65536.0));
        end
        h = ($urandom_range(7) == 0) ? len_t'($urandom) : len_t'($urandom_range(40 << 16));
        r = ($urandom_range(7) == 0) ? len_t'($urandom) : len_t'($urandom_range(40 << 16));
        apply_config(b[0], b[1], b[2], a[0], a[1], a[2], h, r);
    endtask

    // most points are placed along the axis near the surface, the rest anywhere
    task automatic random_phase(int n_items, bit may_idle, bit pause_midway);
        coord_t p [3];
        longint t;
        longint hh;
        longint rr;
        for (int j = 0; j < n_items; j++)
        begin
            if (pause_midway && j == n_items / 2)
            begin
                stop_feed();
                wait_results_out();
            end
            hh = longint'(sb.height);
            rr = longint'(sb.radius);
            if ($urandom_range(4) == 0)
                for (int i = 0; i < 3; i++)
                    p[i] = $urandom;
            else
            begin
                t = pick_between(-(hh / 8) - 2, hh + hh / 8 + 2);
                for (int i = 0; i < 3; i++)
                    p[i] = coord_t'(longint'(sb.base[i]) + ((t * longint'(sb.axis[i])) >>> 16)
                                    + pick_between(-rr - 2, rr + 2));
            end
            feed_point(p[0], p[1], p[2], may_idle);
        end
    endtask

    initial
    begin
        #2000000;
        $display("FAIL point_in_cylinder_test");
        $finish;
    end

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        point_x   = '0;
        point_y   = '0;
        point_z   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // unit cylinder on z out of reset: caps, tolerance band, rim, extremes
        feed_point(0, 0, 0, 1'b0);
        feed_point(0, 0, 65536, 1'b0);
        feed_point(0, 0, 65537, 1'b0);
        feed_point(0, 0, 65538, 1'b0);
        feed_point(0, 0, -1, 1'b0);
        feed_point(0, 0, -2, 1'b0);
        feed_point(65536, 0, 32768, 1'b0);
        feed_point(65537, 0, 32768, 1'b0);
        feed_point(46341, -46341, 100, 1'b0);
        feed_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        feed_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);

        // zero axis, zero height, widest radius, base at the corners of range
        apply_config(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 31'h7FFF_FFFF);
        cfg_write(REG_SPARE_FIRST, 32'hFFFF_FFFF);
        cfg_write(REG_SPARE_LAST, 32'h0000_0000);
        feed_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1'b0);
        feed_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0);
        feed_point(0, 0, 5, 1'b0);
        feed_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);

        // axis far from unit length, tallest cylinder, zero radius
        apply_config(0, 0, 0, 18'sh1FFFF, 18'sh20000, 18'sd65536, 31'h7FFF_FFFF, 0);
        feed_point(0, 0, 0, 1'b0);
        feed_point(1, 0, 0, 1'b0);
        feed_point(-1, 0, 0, 1'b0);
        feed_point(0, 1, 0, 1'b0);
        feed_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        feed_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);

        for (int ph = 0; ph < 7; ph++)
        begin
            random_config();
            random_phase(200, ph != 3, ph == 1);
        end

        stop_feed();
        wait_results_out();
        repeat (12) @(posedge clk);
        if (sb.errors == 0 && sb.verdict_q.size() == 0)
            $display("PASS point_in_cylinder_test");
        else
            $display("FAIL point_in_cylinder_test");
        $finish;
    end

endmodule
